@@ rtl/rtsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsm_pkg
// Shared types and constants for the resistive touch sample mapper: request
// and result layouts, calibration register map and arithmetic constants.
// ----------------------------------------------------------------------------
package rtsm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int PRESSURE_W = 13;
    localparam int PIXEL_X_W  = 9;
    localparam int PIXEL_Y_W  = 8;
    localparam int SUM_W      = 15;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Division by five as a multiply by a rounded-up reciprocal and a shift.
    localparam logic [15:0] MEAN_RECIP = 16'd52429;
    localparam int          MEAN_SHIFT = 18;

    // Quotient bits resolved by the divider pipeline, one per stage.
    localparam int DIV_BITS = 12;

    // Lane pipeline stages: sum, mean, product, magnitude, overflow check,
    // one stage per quotient bit, clamp.
    localparam int LANE_LAT = 5 + DIV_BITS + 1;

    localparam logic [PRESSURE_W-1:0] FULL_SCALE = 13'd4095;

    localparam logic [SAMPLE_W-1:0] X_LOW_RST  = 12'd650;
    localparam logic [SAMPLE_W-1:0] X_HIGH_RST = 12'd3200;
    localparam logic [SAMPLE_W-1:0] Y_LOW_RST  = 12'd650;
    localparam logic [SAMPLE_W-1:0] Y_HIGH_RST = 12'd3100;
    localparam logic [SAMPLE_W-1:0] THRESH_RST = 12'd350;

    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] z1_sample;
        logic [SAMPLE_W-1:0] z2_sample;
        logic [SAMPLE_W-1:0] x_sample_0;
        logic [SAMPLE_W-1:0] x_sample_1;
        logic [SAMPLE_W-1:0] x_sample_2;
        logic [SAMPLE_W-1:0] x_sample_3;
        logic [SAMPLE_W-1:0] x_sample_4;
        logic [SAMPLE_W-1:0] y_sample_0;
        logic [SAMPLE_W-1:0] y_sample_1;
        logic [SAMPLE_W-1:0] y_sample_2;
        logic [SAMPLE_W-1:0] y_sample_3;
        logic [SAMPLE_W-1:0] y_sample_4;
    } t_touch_req;

    typedef struct packed {
        logic                  pressed;
        logic [PRESSURE_W-1:0] pressure;
        logic [PIXEL_X_W-1:0]  pixel_x;
        logic [PIXEL_Y_W-1:0]  pixel_y;
        logic [SAMPLE_W-1:0]   raw_x_mean;
        logic [SAMPLE_W-1:0]   raw_y_mean;
    } t_touch_res;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_raw_low;
        logic [SAMPLE_W-1:0] x_raw_high;
        logic [SAMPLE_W-1:0] y_raw_low;
        logic [SAMPLE_W-1:0] y_raw_high;
        logic [SAMPLE_W-1:0] press_threshold;
    } t_cal;

    typedef struct packed {
        logic [SAMPLE_W-1:0] coord;
        logic [SAMPLE_W-1:0] mean;
    } t_lane_out;

endpackage

@@ rtl/resistive_touch_sample_mapper.sv @@
// ----------------------------------------------------------------------------
// resistive_touch_sample_mapper
// Turns one touch poll into pen state, pressure, calibrated screen
// coordinates and raw sample means.
// ----------------------------------------------------------------------------
// Usage: drive a poll on i_req and raise start; busy stays low, so a request
// is taken on every cycle that start is high, one per cycle if need be.
// Each request yields exactly one result on o_res, shown for one cycle with
// o_strobe high once it has passed the lanes and the output register. Results
// leave in request order and the sink must take them as they come.
// The X and Y axes run in two lanes side by side; each lane's latency is set
// by its restoring divider, which resolves one quotient bit per stage, so
// throughput is one request per cycle.
// Calibration registers sit on the APB-style port at byte addresses 0, 4, 8,
// 12 and 16. The user must write them only while no request is in flight; the
// block does not enforce it. pready is always high. Reset restores the
// defaults and empties the pipeline; earlier requests then give no strobe.
// ----------------------------------------------------------------------------
module resistive_touch_sample_mapper
    import rtsm_pkg::*;
#(
    parameter int H_RES = 320,
    parameter int V_RES = 240
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_touch_req            i_req,
    output logic                  o_strobe,
    output t_touch_res            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cal                  cal;
    t_touch_req            r_req;
    logic [LANE_LAT:0]     r_vld;
    logic [LANE_LAT:1]     r_down;
    logic [PRESSURE_W-1:0] r_prs [1:LANE_LAT];
    logic [PRESSURE_W-1:0] n_prs;
    t_lane_out             lane_x;
    t_lane_out             lane_y;
    logic                  r_strobe;
    t_touch_res            r_res;
    logic                  down_now;

    assign busy = 1'b0;

    rtsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal)
    );

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req <= i_req;
        end
    end

    // Pressure never goes negative with 12-bit samples, so no clamp is needed.
    assign n_prs = FULL_SCALE + PRESSURE_W'(r_req.z1_sample)
                   - PRESSURE_W'(r_req.z2_sample);
    assign down_now = n_prs > PRESSURE_W'(cal.press_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_LAT-1:0], start};
        end
    end

    // Pressure and pen state travel alongside the lanes.
    always_ff @(posedge i_clk) begin
        r_prs[1]  <= n_prs;
        r_down[1] <= down_now;
        for (int k = 2; k <= LANE_LAT; k++) begin
            r_prs[k]  <= r_prs[k-1];
            r_down[k] <= r_down[k-1];
        end
    end

    rtsm_lane #(.RES(H_RES)) u_lane_x (
        .i_clk  (i_clk),
        .i_s0   (r_req.x_sample_0),
        .i_s1   (r_req.x_sample_1),
        .i_s2   (r_req.x_sample_2),
        .i_s3   (r_req.x_sample_3),
        .i_s4   (r_req.x_sample_4),
        .i_lo   (cal.x_raw_low),
        .i_hi   (cal.x_raw_high),
        .o_lane (lane_x)
    );

    rtsm_lane #(.RES(V_RES)) u_lane_y (
        .i_clk  (i_clk),
        .i_s0   (r_req.y_sample_0),
        .i_s1   (r_req.y_sample_1),
        .i_s2   (r_req.y_sample_2),
        .i_s3   (r_req.y_sample_3),
        .i_s4   (r_req.y_sample_4),
        .i_lo   (cal.y_raw_low),
        .i_hi   (cal.y_raw_high),
        .o_lane (lane_y)
    );

    // Merge: a released pen reports zero coordinates and means.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[LANE_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.pressed    <= r_down[LANE_LAT];
        r_res.pressure   <= r_prs[LANE_LAT];
        r_res.pixel_x    <= r_down[LANE_LAT] ? lane_x.coord[PIXEL_X_W-1:0] : '0;
        r_res.pixel_y    <= r_down[LANE_LAT] ? lane_y.coord[PIXEL_Y_W-1:0] : '0;
        r_res.raw_x_mean <= r_down[LANE_LAT] ? lane_x.mean : '0;
        r_res.raw_y_mean <= r_down[LANE_LAT] ? lane_y.mean : '0;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

@@ rtl/rtsm_regs.sv @@
// ----------------------------------------------------------------------------
// rtsm_regs
// APB-style calibration register file: window limits for both axes and the
// pen-down pressure threshold.
// ----------------------------------------------------------------------------
module rtsm_regs
    import rtsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cal                  o_cal
);

    t_cal       r_cal;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign o_cal   = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.x_raw_low       <= X_LOW_RST;
            r_cal.x_raw_high      <= X_HIGH_RST;
            r_cal.y_raw_low       <= Y_LOW_RST;
            r_cal.y_raw_high      <= Y_HIGH_RST;
            r_cal.press_threshold <= THRESH_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_X_LOW:  r_cal.x_raw_low       <= pwdata[SAMPLE_W-1:0];
                REG_X_HIGH: r_cal.x_raw_high      <= pwdata[SAMPLE_W-1:0];
                REG_Y_LOW:  r_cal.y_raw_low       <= pwdata[SAMPLE_W-1:0];
                REG_Y_HIGH: r_cal.y_raw_high      <= pwdata[SAMPLE_W-1:0];
                REG_THRESH: r_cal.press_threshold <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_X_LOW:  prdata[SAMPLE_W-1:0] = r_cal.x_raw_low;
            REG_X_HIGH: prdata[SAMPLE_W-1:0] = r_cal.x_raw_high;
            REG_Y_LOW:  prdata[SAMPLE_W-1:0] = r_cal.y_raw_low;
            REG_Y_HIGH: prdata[SAMPLE_W-1:0] = r_cal.y_raw_high;
            REG_THRESH: prdata[SAMPLE_W-1:0] = r_cal.press_threshold;
            default:    prdata = '0;
        endcase
    end

endmodule

@@ rtl/rtsm_lane.sv @@
// ----------------------------------------------------------------------------
// rtsm_lane
// One axis: averages five samples, maps the mean through the calibration
// window with a pipelined divider on magnitudes, clamps and inverts.
// ----------------------------------------------------------------------------
module rtsm_lane
    import rtsm_pkg::*;
#(
    parameter int RES = 320
) (
    input  logic                i_clk,
    input  logic [SAMPLE_W-1:0] i_s0,
    input  logic [SAMPLE_W-1:0] i_s1,
    input  logic [SAMPLE_W-1:0] i_s2,
    input  logic [SAMPLE_W-1:0] i_s3,
    input  logic [SAMPLE_W-1:0] i_s4,
    input  logic [SAMPLE_W-1:0] i_lo,
    input  logic [SAMPLE_W-1:0] i_hi,
    output t_lane_out           o_lane
);

    localparam logic [SAMPLE_W-1:0] SPAN = SAMPLE_W'(RES - 1);
    localparam int PROD_W = 2 * (SAMPLE_W + 1);
    localparam int NUM_W  = 2 * SAMPLE_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] low;
        logic [SAMPLE_W-1:0] den;
        logic                ovf;
        logic                zero;
        logic [SAMPLE_W-1:0] mean;
    } t_div_st;

    logic [SUM_W-1:0]             r_sum;
    logic [SAMPLE_W-1:0]          r_mean;
    logic [SUM_W+15:0]            mean_prod;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [SAMPLE_W:0]     r_wid;
    logic [SAMPLE_W-1:0]          r_mean3;
    logic [NUM_W-1:0]             r_num;
    logic [SAMPLE_W-1:0]          r_den;
    logic                         r_zero;
    logic [SAMPLE_W-1:0]          r_mean4;
    t_div_st                      r_st [0:DIV_BITS];
    t_lane_out                    r_out;

    logic signed [SAMPLE_W:0]     diff;
    logic signed [SAMPLE_W:0]     wid;
    logic signed [PROD_W-1:0]     diff_ext;
    logic signed [PROD_W-1:0]     span_ext;
    logic signed [PROD_W-1:0]     prod_neg;
    logic signed [SAMPLE_W:0]     wid_neg;
    logic                         neg_p;
    logic                         neg_w;
    logic [SAMPLE_W-1:0]          v;

    // Mean of five: 15-bit sum times the reciprocal, exact for every sum.
    always_ff @(posedge i_clk) begin
        r_sum  <= SUM_W'(i_s0) + SUM_W'(i_s1) + SUM_W'(i_s2) + SUM_W'(i_s3)
                  + SUM_W'(i_s4);
        r_mean <= mean_prod[MEAN_SHIFT+SAMPLE_W-1:MEAN_SHIFT];
    end

    assign mean_prod = (SUM_W+16)'(r_sum) * (SUM_W+16)'(MEAN_RECIP);

    assign diff     = $signed({1'b0, r_mean}) - $signed({1'b0, i_lo});
    assign wid      = $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
    assign diff_ext = PROD_W'(diff);
    assign span_ext = $signed(PROD_W'(SPAN));

    always_ff @(posedge i_clk) begin
        r_prod  <= diff_ext * span_ext;
        r_wid   <= wid;
        r_mean3 <= r_mean;
    end

    // Work on magnitudes; a negative quotient clamps to zero, as does an
    // empty window.
    assign neg_p    = r_prod[PROD_W-1];
    assign neg_w    = r_wid[SAMPLE_W];
    assign prod_neg = -r_prod;
    assign wid_neg  = -r_wid;

    always_ff @(posedge i_clk) begin
        r_num   <= neg_p ? prod_neg[NUM_W-1:0] : r_prod[NUM_W-1:0];
        r_den   <= neg_w ? wid_neg[SAMPLE_W-1:0] : r_wid[SAMPLE_W-1:0];
        r_zero  <= (r_wid == '0) | (neg_p ^ neg_w);
        r_mean4 <= r_mean3;
    end

    // Any quotient of 4096 or more saturates; otherwise the upper half of
    // the numerator is already below the divisor.
    always_ff @(posedge i_clk) begin
        r_st[0].rem  <= r_num[NUM_W-1:DIV_BITS];
        r_st[0].quo  <= '0;
        r_st[0].low  <= r_num[DIV_BITS-1:0];
        r_st[0].den  <= r_den;
        r_st[0].ovf  <= r_num[NUM_W-1:DIV_BITS] >= r_den;
        r_st[0].zero <= r_zero;
        r_st[0].mean <= r_mean4;
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
        logic [SAMPLE_W:0] trial;
        logic              fits;

        assign trial = {r_st[k-1].rem, r_st[k-1].low[DIV_BITS-1]};
        assign fits  = trial >= {1'b0, r_st[k-1].den};

        always_ff @(posedge i_clk) begin
            r_st[k].rem  <= fits ? SAMPLE_W'(trial - {1'b0, r_st[k-1].den})
                                 : trial[SAMPLE_W-1:0];
            r_st[k].quo  <= {r_st[k-1].quo[DIV_BITS-2:0], fits};
            r_st[k].low  <= {r_st[k-1].low[DIV_BITS-2:0], 1'b0};
            r_st[k].den  <= r_st[k-1].den;
            r_st[k].ovf  <= r_st[k-1].ovf;
            r_st[k].zero <= r_st[k-1].zero;
            r_st[k].mean <= r_st[k-1].mean;
        end
    end

    always_comb begin
        if (r_st[DIV_BITS].zero) begin
            v = '0;
        end else if (r_st[DIV_BITS].ovf || (r_st[DIV_BITS].quo > SPAN)) begin
            v = SPAN;
        end else begin
            v = r_st[DIV_BITS].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.coord <= SPAN - v;
        r_out.mean  <= r_st[DIV_BITS].mean;
    end

    assign o_lane = r_out;

endmodule
